/* rtl/hse_pkg.sv */
// Heap sort engine package: beat payload types, datapath op codes and the
// command/status structs between controller and datapath. No dependencies.
package hse_pkg;

    localparam int DATA_W = 32;

    // Input beat: one value of the set, is_last closes the set
    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     is_last;
    } in_item_t;

    // Output beat: one sorted value
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } out_item_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BUILD_NEXT,
        OP_LATCH_V,
        OP_READ_KIDS,
        OP_SIFT_STEP,
        OP_SORT_INIT,
        OP_SORT_READ,
        OP_SORT_SWAP,
        OP_OUT_INIT,
        OP_OUT_READ,
        OP_OUT_LATCH,
        OP_OUT_HOLD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic k_zero;     // loop index is zero
        logic k_le1;      // loop index is zero or one
        logic sift_done;  // current sift step settled the value
        logic last_beat;  // input beat with is_last accepted this cycle
        logic out_fire;   // output beat taken this cycle
        logic out_last;   // output register holds the final value
    } status_t;

endpackage

/* rtl/hse_stream_if.sv */
// Valid/ready stream channel carrying one payload struct per beat.
// Payload type is a parameter; used with types from hse_pkg.
interface hse_stream_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/hse_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* rtl/hse_datapath.sv */
// Heap sort datapath: value store, counters, sift compare and output register.
// Depends on hse_pkg, hse_stream_if and hse_ram.
module hse_datapath #(
    parameter int DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  hse_pkg::cmd_t  cmd,
    output hse_pkg::status_t status,
    hse_stream_if.sink     sample_in,
    hse_stream_if.source   result_out
);

    import hse_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CHW = AW + 2;

    logic [CW-1:0]            count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic [CW-1:0]            k_reg, k_next;
    logic [CW-1:0]            size_reg, size_next;
    logic [AW-1:0]            node_reg, node_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] v_reg, v_next;
    out_item_t                out_reg, out_next;

    logic                     in_fire, out_fire, room;
    logic [CW-1:0]            n_new, km1;
    logic [CHW-1:0]           l_idx, r_idx;
    logic                     l_ok, r_ok, take_l, take_r;
    logic signed [DATA_W-1:0] rd_a, rd_b, best_l, step_data;

    logic                     we;
    logic [AW-1:0]            waddr, raddr_a, raddr_b;
    logic [DATA_W-1:0]        wdata, rdata_a, rdata_b;

    hse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign rd_a = $signed(rdata_a);
    assign rd_b = $signed(rdata_b);

    // Handshakes
    assign sample_in.ready  = (cmd.op == OP_LOAD);
    assign in_fire          = sample_in.valid && sample_in.ready;
    assign result_out.valid = out_valid_reg;
    assign result_out.payload = out_reg;
    assign out_fire         = result_out.valid && result_out.ready;

    // Store fill
    assign room  = (count_reg < CW'(DEPTH));
    assign n_new = room ? (count_reg + CW'(1)) : count_reg;
    assign km1   = k_reg - CW'(1);

    // Children of the sifting node and the compare; one spare bit so the
    // right child of the last node does not wrap
    assign l_idx  = {1'b0, node_reg, 1'b0} + CHW'(1);
    assign r_idx  = {1'b0, node_reg, 1'b0} + CHW'(2);
    assign l_ok   = (l_idx < CHW'(size_reg));
    assign r_ok   = (r_idx < CHW'(size_reg));
    assign take_l = l_ok && (rd_a > v_reg);
    assign best_l = take_l ? rd_a : v_reg;
    assign take_r = r_ok && (rd_b > best_l);
    assign step_data = take_r ? rd_b : best_l;

    // Status to the controller
    always_comb
    begin
        status.k_zero    = (k_reg == '0);
        status.k_le1     = (k_reg < CW'(2));
        status.sift_done = !take_l && !take_r;
        status.last_beat = in_fire && sample_in.payload.is_last;
        status.out_fire  = out_fire;
        status.out_last  = out_reg.last_out;
    end

    // Store read and write ports
    always_comb
    begin
        we      = 1'b0;
        waddr   = count_reg[AW-1:0];
        wdata   = sample_in.payload.sample_value;
        raddr_a = '0;
        raddr_b = '0;
        case (cmd.op)
            OP_LOAD:
            begin
                we = in_fire && room;
            end
            OP_BUILD_NEXT:
            begin
                raddr_a = km1[AW-1:0];
            end
            OP_READ_KIDS:
            begin
                raddr_a = l_idx[AW-1:0];
                raddr_b = r_idx[AW-1:0];
            end
            OP_SIFT_STEP:
            begin
                we    = 1'b1;
                waddr = node_reg;
                wdata = step_data;
            end
            OP_SORT_READ:
            begin
                raddr_a = '0;
                raddr_b = km1[AW-1:0];
            end
            OP_SORT_SWAP:
            begin
                we    = 1'b1;
                waddr = km1[AW-1:0];
                wdata = rd_a;
            end
            OP_OUT_READ:
            begin
                raddr_a = k_reg[AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Register next values
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        size_next      = size_reg;
        node_next      = node_reg;
        out_valid_next = out_valid_reg;
        v_next         = v_reg;
        out_next       = out_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                if (in_fire)
                begin
                    count_next = n_new;
                    if (!room)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (sample_in.payload.is_last)
                    begin
                        k_next    = n_new >> 1;
                        size_next = n_new;
                    end
                end
            end
            OP_BUILD_NEXT:
            begin
                node_next = km1[AW-1:0];
                k_next    = km1;
            end
            OP_LATCH_V:
            begin
                v_next = rd_a;
            end
            OP_SIFT_STEP:
            begin
                if (take_r)
                begin
                    node_next = r_idx[AW-1:0];
                end
                else if (take_l)
                begin
                    node_next = l_idx[AW-1:0];
                end
            end
            OP_SORT_INIT:
            begin
                k_next = count_reg;
            end
            OP_SORT_SWAP:
            begin
                v_next    = rd_b;
                node_next = '0;
                size_next = km1;
                k_next    = km1;
            end
            OP_OUT_INIT:
            begin
                k_next = '0;
            end
            OP_OUT_LATCH:
            begin
                out_next.sorted_value = rd_a;
                out_next.last_out     = ((k_reg + CW'(1)) == count_reg);
                out_next.overflow     = ovf_reg;
                out_valid_next        = 1'b1;
            end
            OP_OUT_HOLD:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (out_reg.last_out)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        k_next = k_reg + CW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            size_reg      <= '0;
            node_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            size_reg      <= size_next;
            node_reg      <= node_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        out_reg <= out_next;
    end

endmodule

/* rtl/hse_ctrl.sv */
// Heap sort controller: sequences load, heap build, sort-down and output.
// Depends on hse_pkg.
module hse_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  hse_pkg::status_t status,
    output hse_pkg::cmd_t    cmd
);

    import hse_pkg::*;

    typedef enum logic [11:0] {
        S_LOAD      = 12'b0000_0000_0001,
        S_BUILD_CHK = 12'b0000_0000_0010,
        S_BUILD_LAT = 12'b0000_0000_0100,
        S_SIFT_RD   = 12'b0000_0000_1000,
        S_SIFT_CMP  = 12'b0000_0001_0000,
        S_SORT_INIT = 12'b0000_0010_0000,
        S_SORT_CHK  = 12'b0000_0100_0000,
        S_SORT_SWP  = 12'b0000_1000_0000,
        S_OUT_INIT  = 12'b0001_0000_0000,
        S_OUT_RD    = 12'b0010_0000_0000,
        S_OUT_LAT   = 12'b0100_0000_0000,
        S_OUT_HOLD  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   sorting_reg, sorting_next;

    // Next state and command
    always_comb
    begin
        state_next   = state_reg;
        sorting_next = sorting_reg;
        cmd.op       = OP_NONE;
        case (state_reg)
            S_LOAD:
            begin
                cmd.op = OP_LOAD;
                if (status.last_beat)
                begin
                    sorting_next = 1'b0;
                    state_next   = S_BUILD_CHK;
                end
            end
            S_BUILD_CHK:
            begin
                if (status.k_zero)
                begin
                    state_next = S_SORT_INIT;
                end
                else
                begin
                    cmd.op     = OP_BUILD_NEXT;
                    state_next = S_BUILD_LAT;
                end
            end
            S_BUILD_LAT:
            begin
                cmd.op     = OP_LATCH_V;
                state_next = S_SIFT_RD;
            end
            S_SIFT_RD:
            begin
                cmd.op     = OP_READ_KIDS;
                state_next = S_SIFT_CMP;
            end
            S_SIFT_CMP:
            begin
                cmd.op = OP_SIFT_STEP;
                if (!status.sift_done)
                begin
                    state_next = S_SIFT_RD;
                end
                else if (sorting_reg)
                begin
                    state_next = S_SORT_CHK;
                end
                else
                begin
                    state_next = S_BUILD_CHK;
                end
            end
            S_SORT_INIT:
            begin
                cmd.op       = OP_SORT_INIT;
                sorting_next = 1'b1;
                state_next   = S_SORT_CHK;
            end
            S_SORT_CHK:
            begin
                if (status.k_le1)
                begin
                    state_next = S_OUT_INIT;
                end
                else
                begin
                    cmd.op     = OP_SORT_READ;
                    state_next = S_SORT_SWP;
                end
            end
            S_SORT_SWP:
            begin
                cmd.op     = OP_SORT_SWAP;
                state_next = S_SIFT_RD;
            end
            S_OUT_INIT:
            begin
                cmd.op     = OP_OUT_INIT;
                state_next = S_OUT_RD;
            end
            S_OUT_RD:
            begin
                cmd.op     = OP_OUT_READ;
                state_next = S_OUT_LAT;
            end
            S_OUT_LAT:
            begin
                cmd.op     = OP_OUT_LATCH;
                state_next = S_OUT_HOLD;
            end
            S_OUT_HOLD:
            begin
                cmd.op = OP_OUT_HOLD;
                if (status.out_fire)
                begin
                    state_next = status.out_last ? S_LOAD : S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            sorting_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sorting_reg <= sorting_next;
        end
    end

endmodule

/* rtl/heap_sort_engine.sv */
// Heap sort engine. Loading takes one beat per cycle into a DEPTH-entry store.
// After the last beat: heap build sifts down each inner node, sort-down swaps the
// root with the last value and sifts it down (each sift step reads both children
// at once through the dual-read store), then output sends one beat at a time, the
// next only after the sink takes one. Input is held off until the final output beat.
// Reset (rst_n, async) empties the set; store contents are not cleared.
module heap_sort_engine #(
    parameter int DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    hse_stream_if.sink   sample_in,
    hse_stream_if.source result_out
);

    import hse_pkg::*;

    cmd_t    cmd;
    status_t status;

    hse_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    hse_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .sample_in  (sample_in),
        .result_out (result_out)
    );

endmodule
